@@ hw/rtl/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// qvr_pkg - shared types and constants for the quaternion vector rotator
// Payload structs, register indexes and the sideband that rides the
// normalisation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int COMP_W        = 16;

	// configuration register indexes
	localparam logic [1:0] REG_ROT_X = 2'd0;
	localparam logic [1:0] REG_ROT_Y = 2'd1;
	localparam logic [1:0] REG_ROT_Z = 2'd2;
	localparam logic [1:0] REG_ROT_W = 2'd3;

	// input transaction
	typedef struct packed {
		logic signed [COMP_W-1:0] vec_x;
		logic signed [COMP_W-1:0] vec_y;
		logic signed [COMP_W-1:0] vec_z;
	} vec_t;

	// result transaction
	typedef struct packed {
		logic signed [COMP_W-1:0] out_x;
		logic signed [COMP_W-1:0] out_y;
		logic signed [COMP_W-1:0] out_z;
		logic                     zero_length;
	} res_t;

	// sideband through the square root: magnitudes, signs, zero flag
	typedef struct packed {
		logic [2:0][COMP_W-1:0] mag;
		logic [2:0]             neg;
		logic                   zero;
	} norm_side_t;

	// sideband through the divider
	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} div_side_t;

endpackage

@@ hw/rtl/qvr_isqrt.sv @@
// ----------------------------------------------------------------------------
// qvr_isqrt - pipelined integer square root
// floor(sqrt(n * 2^32)) for a 32-bit n, one root bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module qvr_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [31:0]            in_n,
	input  qvr_pkg::norm_side_t    in_side,
	output logic                   out_valid,
	output logic [31:0]            out_root,
	output qvr_pkg::norm_side_t    out_side
);

	localparam int STAGES = 32;

	logic                valid_p [0:STAGES];
	logic [31:0]         root_p  [0:STAGES];
	logic [33:0]         rem_p   [0:STAGES];
	logic [31:0]         n_p     [0:15];
	qvr_pkg::norm_side_t side_p  [0:STAGES];

	assign valid_p[0] = in_valid;
	assign root_p[0]  = '0;
	assign rem_p[0]   = '0;
	assign n_p[0]     = in_n;
	assign side_p[0]  = in_side;

	genvar k;
	generate
		for (k = 0; k < STAGES; k++) begin : g_stage
			logic [1:0]  pair;
			logic [35:0] rem_sh;
			logic [35:0] trial;
			logic        ge;

			// next radicand pair: top half from n, bottom half is zero
			if (k < 16) begin : g_pair
				assign pair = n_p[k][31-2*k -: 2];
			end else begin : g_zero
				assign pair = 2'b00;
			end

			assign rem_sh = {rem_p[k], pair};
			assign trial  = {2'b00, root_p[k], 2'b01};
			assign ge     = (rem_sh >= trial);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_p[k+1] <= 1'b0;
				end else if (en) begin
					valid_p[k+1] <= valid_p[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_p[k+1]  <= ge ? 34'(rem_sh - trial) : 34'(rem_sh);
					root_p[k+1] <= {root_p[k][30:0], ge};
					side_p[k+1] <= side_p[k];
				end
			end

			if (k < 15) begin : g_ncarry
				always_ff @(posedge clk) begin
					if (en) begin
						n_p[k+1] <= n_p[k];
					end
				end
			end
		end
	endgenerate

	assign out_valid = valid_p[STAGES];
	assign out_root  = root_p[STAGES];
	assign out_side  = side_p[STAGES];

endmodule

@@ hw/rtl/qvr_div.sv @@
// ----------------------------------------------------------------------------
// qvr_div - pipelined restoring divider, three lanes, shared divisor
// Quotient of rounded (mag * 2^(FRAC_BITS+16) + den/2) / den, one bit a stage.
// ----------------------------------------------------------------------------
module qvr_div #(
	parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [31:0]                    in_den,
	input  logic [2:0][qvr_pkg::COMP_W-1:0] in_mag,
	input  qvr_pkg::div_side_t             in_side,
	output logic                           out_valid,
	output logic [2:0][FRAC_BITS:0]        out_quo,
	output qvr_pkg::div_side_t             out_side
);

	localparam int QW = FRAC_BITS + 1;
	localparam int RW = FRAC_BITS + 33;

	logic                 valid_p [0:QW];
	logic [31:0]          den_p   [0:QW];
	logic [2:0][RW-1:0]   rem_p   [0:QW];
	logic [2:0][QW-1:0]   quo_p   [0:QW];
	qvr_pkg::div_side_t   side_p  [0:QW];

	// numerator with the half-divisor rounding term folded in
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_p[0][i] = (RW'(in_mag[i]) << (FRAC_BITS + 16)) + RW'(in_den[31:1]);
			quo_p[0][i] = '0;
		end
	end

	assign valid_p[0] = in_valid;
	assign den_p[0]   = in_den;
	assign side_p[0]  = in_side;

	genvar j;
	generate
		for (j = 0; j < QW; j++) begin : g_stage
			logic [RW-1:0] sub;
			logic [2:0]    ge;

			assign sub = RW'(den_p[j]) << (QW - 1 - j);

			always_comb begin
				for (int i = 0; i < 3; i++) begin
					ge[i] = (rem_p[j][i] >= sub);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_p[j+1] <= 1'b0;
				end else if (en) begin
					valid_p[j+1] <= valid_p[j];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					for (int i = 0; i < 3; i++) begin
						rem_p[j+1][i] <= ge[i] ? rem_p[j][i] - sub : rem_p[j][i];
						quo_p[j+1][i] <= {quo_p[j][i][QW-2:0], ge[i]};
					end
					den_p[j+1]  <= den_p[j];
					side_p[j+1] <= side_p[j];
				end
			end
		end
	endgenerate

	assign out_valid = valid_p[QW];
	assign out_quo   = quo_p[QW];
	assign out_side  = side_p[QW];

endmodule

@@ hw/rtl/quaternion_vector_rotate_unit.sv @@
// Rotation and results are Q2.14 at the default FRAC_BITS.
// Throughput: one vector per cycle unless a held result stalls the pipeline;
// 3 front, 32 square-root, FRAC_BITS + 1 divider and 5 product stages move together.
// A held result freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and sets the rotation to identity (w = 1.0).
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit - rotate a normalised 3D vector by q
// Normalises each vector to unit length, then forms q * v * conj(q) in
// fixed point with two Hamilton products and saturates the result.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit #(
	parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vec_valid,
	output logic                vec_stall,
	input  qvr_pkg::vec_t       vec_data,
	output logic                res_valid,
	input  logic                res_stall,
	output qvr_pkg::res_t       res_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int CW  = qvr_pkg::COMP_W;
	localparam int QW  = FRAC_BITS + 1;
	localparam int UW  = FRAC_BITS + 2;
	localparam int AW  = FRAC_BITS + 20;
	localparam int PW  = 20;
	localparam int BW  = 38;
	localparam logic [32:0]           ONE_F   = 33'd1 << FRAC_BITS;
	localparam logic signed [AW-1:0]  HALF_A  = AW'(ONE_F >> 1);
	localparam logic signed [BW-1:0]  HALF_B  = BW'(ONE_F >> 1);
	localparam logic signed [BW-1:0]  SAT_HI  = 38'sd32767;
	localparam logic signed [BW-1:0]  SAT_LO  = -38'sd32768;

	// rotation quaternion registers
	logic signed [CW-1:0] rot_x_q, rot_y_q, rot_z_q, rot_w_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q <= '0;
			rot_y_q <= '0;
			rot_z_q <= '0;
			rot_w_q <= ONE_F[CW-1:0];
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qvr_pkg::REG_ROT_X: rot_x_q <= cfg_data;
				qvr_pkg::REG_ROT_Y: rot_y_q <= cfg_data;
				qvr_pkg::REG_ROT_Z: rot_z_q <= cfg_data;
				qvr_pkg::REG_ROT_W: rot_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances unless a finished result is held
	logic en;
	assign en        = !res_valid || !res_stall;
	assign vec_stall = !en;

	// s1: magnitudes, signs, zero detect
	logic                valid_s1;
	logic [2:0][CW-1:0]  mag_s1;
	logic [2:0]          neg_s1;
	logic                zero_s1;
	logic [2:0][CW-1:0]  vin;

	assign vin = {vec_data.vec_x, vec_data.vec_y, vec_data.vec_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vin[i][CW-1];
				mag_s1[i] <= vin[i][CW-1] ? CW'(~vin[i] + 1'b1) : vin[i];
			end
			zero_s1 <= (vin == '0);
		end
	end

	// s2: squares
	logic                valid_s2;
	logic [2:0][31:0]    sq_s2;
	qvr_pkg::norm_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 32'(mag_s1[i]) * 32'(mag_s1[i]);
			end
			side_s2.mag  <= mag_s1;
			side_s2.neg  <= neg_s1;
			side_s2.zero <= zero_s1;
		end
	end

	// s3: squared length, at most 3 * 2^30 so 32 bits hold it
	logic                valid_s3;
	logic [31:0]         n_s3;
	qvr_pkg::norm_side_t side_s3;
	logic [33:0]         n_sum;

	assign n_sum = 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3    <= n_sum[31:0];
			side_s3 <= side_s2;
		end
	end

	// square root of the squared length scaled by 2^32
	logic                sq_valid;
	logic [31:0]         sq_root;
	qvr_pkg::norm_side_t sq_side;

	qvr_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_n      (n_s3),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// unit components by division
	logic                 dv_valid;
	logic [2:0][QW-1:0]   dv_quo;
	qvr_pkg::div_side_t   dv_side;
	qvr_pkg::div_side_t   dv_side_in;

	assign dv_side_in.neg  = sq_side.neg;
	assign dv_side_in.zero = sq_side.zero;

	qvr_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_den    (sq_root),
		.in_mag    (sq_side.mag),
		.in_side   (dv_side_in),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side)
	);

	// s4: signed unit vector
	logic                 valid_s4;
	logic                 zero_s4;
	logic signed [UW-1:0] ux_s4, uy_s4, uz_s4;
	logic signed [UW-1:0] qs [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qs[i] = dv_side.neg[i] ? -$signed(UW'(dv_quo[i])) : $signed(UW'(dv_quo[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= dv_valid;
		end
	end

	// quo lanes are packed x, y, z from the top
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s4   <= qs[2];
			uy_s4   <= qs[1];
			uz_s4   <= qs[0];
			zero_s4 <= dv_side.zero;
		end
	end

	// s5: products of u * conj(q)
	localparam int MA = UW + CW;
	logic                 valid_s5;
	logic                 zero_s5;
	logic signed [MA-1:0] a_s5 [0:11];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5[0]  <= MA'(ux_s4) * MA'(rot_w_q);
			a_s5[1]  <= MA'(uy_s4) * MA'(rot_z_q);
			a_s5[2]  <= MA'(uz_s4) * MA'(rot_y_q);
			a_s5[3]  <= MA'(uy_s4) * MA'(rot_w_q);
			a_s5[4]  <= MA'(uz_s4) * MA'(rot_x_q);
			a_s5[5]  <= MA'(ux_s4) * MA'(rot_z_q);
			a_s5[6]  <= MA'(uz_s4) * MA'(rot_w_q);
			a_s5[7]  <= MA'(ux_s4) * MA'(rot_y_q);
			a_s5[8]  <= MA'(uy_s4) * MA'(rot_x_q);
			a_s5[9]  <= MA'(ux_s4) * MA'(rot_x_q);
			a_s5[10] <= MA'(uy_s4) * MA'(rot_y_q);
			a_s5[11] <= MA'(uz_s4) * MA'(rot_z_q);
			zero_s5  <= zero_s4;
		end
	end

	// s6: first product, rounded
	logic                 valid_s6;
	logic                 zero_s6;
	logic signed [PW-1:0] px_s6, py_s6, pz_s6, pw_s6;
	logic signed [AW-1:0] sa_x, sa_y, sa_z, sa_w;

	assign sa_x = AW'(a_s5[0]) - AW'(a_s5[1]) + AW'(a_s5[2]) + HALF_A;
	assign sa_y = AW'(a_s5[3]) - AW'(a_s5[4]) + AW'(a_s5[5]) + HALF_A;
	assign sa_z = AW'(a_s5[6]) - AW'(a_s5[7]) + AW'(a_s5[8]) + HALF_A;
	assign sa_w = AW'(a_s5[9]) + AW'(a_s5[10]) + AW'(a_s5[11]) + HALF_A;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s6   <= PW'(sa_x >>> FRAC_BITS);
			py_s6   <= PW'(sa_y >>> FRAC_BITS);
			pz_s6   <= PW'(sa_z >>> FRAC_BITS);
			pw_s6   <= PW'(sa_w >>> FRAC_BITS);
			zero_s6 <= zero_s5;
		end
	end

	// s7: products of q * p
	localparam int MB = PW + CW;
	logic                 valid_s7;
	logic                 zero_s7;
	logic signed [MB-1:0] b_s7 [0:11];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s7[0]  <= MB'(rot_w_q) * MB'(px_s6);
			b_s7[1]  <= MB'(rot_x_q) * MB'(pw_s6);
			b_s7[2]  <= MB'(rot_y_q) * MB'(pz_s6);
			b_s7[3]  <= MB'(rot_z_q) * MB'(py_s6);
			b_s7[4]  <= MB'(rot_w_q) * MB'(py_s6);
			b_s7[5]  <= MB'(rot_y_q) * MB'(pw_s6);
			b_s7[6]  <= MB'(rot_z_q) * MB'(px_s6);
			b_s7[7]  <= MB'(rot_x_q) * MB'(pz_s6);
			b_s7[8]  <= MB'(rot_w_q) * MB'(pz_s6);
			b_s7[9]  <= MB'(rot_z_q) * MB'(pw_s6);
			b_s7[10] <= MB'(rot_x_q) * MB'(py_s6);
			b_s7[11] <= MB'(rot_y_q) * MB'(px_s6);
			zero_s7  <= zero_s6;
		end
	end

	// s8: second product, rounded and saturated, into the output register
	logic signed [BW-1:0] sb [0:2];
	logic signed [BW-1:0] rb [0:2];
	logic signed [CW-1:0] rs [0:2];

	always_comb begin
		sb[0] = BW'(b_s7[0]) + BW'(b_s7[1]) + BW'(b_s7[2]) - BW'(b_s7[3]) + HALF_B;
		sb[1] = BW'(b_s7[4]) + BW'(b_s7[5]) + BW'(b_s7[6]) - BW'(b_s7[7]) + HALF_B;
		sb[2] = BW'(b_s7[8]) + BW'(b_s7[9]) + BW'(b_s7[10]) - BW'(b_s7[11]) + HALF_B;
		for (int i = 0; i < 3; i++) begin
			rb[i] = sb[i] >>> FRAC_BITS;
			if (rb[i] > SAT_HI) begin
				rs[i] = 16'sh7fff;
			end else if (rb[i] < SAT_LO) begin
				rs[i] = -16'sh8000;
			end else begin
				rs[i] = CW'(rb[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_data.out_x       <= zero_s7 ? '0 : rs[0];
			res_data.out_y       <= zero_s7 ? '0 : rs[1];
			res_data.out_z       <= zero_s7 ? '0 : rs[2];
			res_data.zero_length <= zero_s7;
		end
	end

	// a zero-length flag always comes with a zero vector
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.zero_length |->
			res_data.out_x == '0 && res_data.out_y == '0 && res_data.out_z == '0)
		else $error("zero-length result carries non-zero components");

	// the normalised x component never exceeds one in magnitude
	a_unit_mag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !zero_s4 |->
			$signed(ux_s4) <= $signed({1'b0, ONE_F[UW-2:0]}) &&
			$signed(ux_s4) >= -$signed({1'b0, ONE_F[UW-2:0]}))
		else $error("unit vector component out of range");

	// a held result freezes the s7 stage too
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(valid_s7) && $stable(zero_s7))
		else $error("pipeline moved while result held");

endmodule

@@ tb/qvr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qvr_checker - result checker for the quaternion vector rotator
// Watches the vector, result and configuration channels, predicts each
// rotated unit vector in fixed point and compares it with what comes out.
// ----------------------------------------------------------------------------
module qvr_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vec_valid,
	input  logic          vec_stall,
	input  qvr_pkg::vec_t vec_data,
	input  logic          res_valid,
	input  logic          res_stall,
	input  qvr_pkg::res_t res_data,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output int            fail_count,
	output int            pending
);

	localparam int FB = qvr_pkg::FRAC_BITS_DEF;

	// rotation held by the checker
	longint        rot_x, rot_y, rot_z, rot_w;
	qvr_pkg::res_t rotated_q[$];

	function automatic longint floor_sqrt(input logic [63:0] n);
		logic [63:0] op, acc, bit_v;
		op = n;
		acc = '0;
		bit_v = 64'd1 << 62;
		while (bit_v > op) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (op >= acc + bit_v) begin
				op = op - (acc + bit_v);
				acc = (acc >> 1) + bit_v;
			end else begin
				acc = acc >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return longint'(acc);
	endfunction

	// floor((t + half) / 2^FB), exact for negatives too
	function automatic longint rnd_q(input longint t);
		longint s;
		s = t + (longint'(1) << (FB - 1));
		return s >>> FB;
	endfunction

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic longint unit_part(input longint v, input longint s);
		longint mag, u;
		mag = (v < 0) ? -v : v;
		u = ((mag << (FB + 16)) + (s >> 1)) / s;
		return (v < 0) ? -u : u;
	endfunction

	function automatic qvr_pkg::res_t rotate_vec(input qvr_pkg::vec_t v);
		qvr_pkg::res_t r;
		longint vx, vy, vz, s, ux, uy, uz, px, py, pz, pw;
		logic [63:0] n;
		vx = longint'(v.vec_x);
		vy = longint'(v.vec_y);
		vz = longint'(v.vec_z);
		r = '0;
		if (vx == 0 && vy == 0 && vz == 0) begin
			r.zero_length = 1'b1;
			return r;
		end
		n = vx * vx + vy * vy + vz * vz;
		s = floor_sqrt(n << 32);
		ux = unit_part(vx, s);
		uy = unit_part(vy, s);
		uz = unit_part(vz, s);
		// v * conj(q)
		px = rnd_q(ux * rot_w - uy * rot_z + uz * rot_y);
		py = rnd_q(uy * rot_w - uz * rot_x + ux * rot_z);
		pz = rnd_q(uz * rot_w - ux * rot_y + uy * rot_x);
		pw = rnd_q(ux * rot_x + uy * rot_y + uz * rot_z);
		// q * p
		r.out_x = clip16(rnd_q(rot_w * px + rot_x * pw + rot_y * pz - rot_z * py));
		r.out_y = clip16(rnd_q(rot_w * py + rot_y * pw + rot_z * px - rot_x * pz));
		r.out_z = clip16(rnd_q(rot_w * pz + rot_z * pw + rot_x * py - rot_y * px));
		return r;
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		qvr_pkg::res_t want;
		if (!arst_n) begin
			rot_x = '0;
			rot_y = '0;
			rot_z = '0;
			rot_w = longint'(1) << FB;
			rotated_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					qvr_pkg::REG_ROT_X: rot_x = longint'($signed(cfg_data));
					qvr_pkg::REG_ROT_Y: rot_y = longint'($signed(cfg_data));
					qvr_pkg::REG_ROT_Z: rot_z = longint'($signed(cfg_data));
					qvr_pkg::REG_ROT_W: rot_w = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: unexpected result transaction, actual %h",
						$time, res_data);
					fail_count++;
				end else begin
					want = rotated_q.pop_front();
					if (want !== res_data) begin
						$display({"%0t: result mismatch, expected x=%0d y=%0d z=%0d zl=%0b,",
							" actual x=%0d y=%0d z=%0d zl=%0b"},
							$time, want.out_x, want.out_y, want.out_z, want.zero_length,
							res_data.out_x, res_data.out_y, res_data.out_z,
							res_data.zero_length);
						fail_count++;
					end
				end
			end
			if (vec_valid && !vec_stall)
				rotated_q.push_back(rotate_vec(vec_data));
			pending = rotated_q.size();
		end
	end

endmodule

@@ tb/tb_quaternion_vector_rotate_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate_unit - stimulus for the quaternion rotator
// Streams directed and random vectors in bursts under several rotations,
// with a stalling receiver, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate_unit;

	localparam int IDLE_LIMIT = 5000;
	localparam int PIPE_DRAIN = 80;

	logic          clk;
	logic          arst_n;
	logic          vec_valid;
	logic          vec_stall;
	qvr_pkg::vec_t vec_data;
	logic          res_valid;
	logic          res_stall;
	qvr_pkg::res_t res_data;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [1:0]    cfg_index;
	logic [15:0]   cfg_data;
	int            fail_count;
	int            pending;
	int            idle_cycles;
	logic          long_hold;

	quaternion_vector_rotate_unit dut (.*);

	qvr_checker u_checker (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (long_hold) begin
			res_stall <= 1'b1;
		end else begin
			case ($urandom_range(0, 3))
				0: res_stall <= ($urandom_range(0, 1) == 0);
				1: res_stall <= ($urandom_range(0, 7) == 0);
				default: res_stall <= 1'b0;
			endcase
		end
	end

	initial begin
		long_hold = 1'b0;
		@(posedge arst_n);
		repeat (400) @(posedge clk);
		long_hold <= 1'b1;
		repeat (200) @(posedge clk);
		long_hold <= 1'b0;
	end

	// watchdog on cycles with no accepted transaction
	always @(posedge clk) begin
		if (!arst_n || (vec_valid && !vec_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_vec(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		vec_valid <= 1'b1;
		vec_data  <= '{vec_x: x, vec_y: y, vec_z: z};
		@(posedge clk);
		while (vec_stall) @(posedge clk);
	endtask

	task automatic gap_vec();
		vec_valid <= 1'b0;
		@(posedge clk);
	endtask

	// leaves valid high; the caller drops it after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_rotation(input logic [15:0] qx, input logic [15:0] qy,
			input logic [15:0] qz, input logic [15:0] qw);
		vec_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		write_reg(qvr_pkg::REG_ROT_X, qx);
		write_reg(qvr_pkg::REG_ROT_Y, qy);
		write_reg(qvr_pkg::REG_ROT_Z, qz);
		write_reg(qvr_pkg::REG_ROT_W, qw);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 8)) - 4);
			3: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	// random vectors in bursts
	task automatic random_bursts(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				if ($urandom_range(0, 30) == 0)
					send_vec(16'h0, 16'h0, 16'h0);
				else
					send_vec(rand_comp(), rand_comp(), rand_comp());
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				repeat ($urandom_range(1, 6)) gap_vec();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		vec_valid = 1'b0;
		vec_data  = '0;
		cfg_valid = 1'b0;
		cfg_index = qvr_pkg::REG_ROT_X;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed vectors at reset rotation (identity)
		send_vec(16'h0, 16'h0, 16'h0);
		send_vec(16'h7fff, 16'h0, 16'h0);
		send_vec(16'h0, 16'h8000, 16'h0);
		send_vec(16'h0, 16'h0, 16'h0001);
		send_vec(16'h8000, 16'h8000, 16'h8000);
		send_vec(16'h7fff, 16'h7fff, 16'h7fff);
		send_vec(16'h8000, 16'h7fff, 16'h0001);
		send_vec(16'hffff, 16'h0001, 16'hffff);
		send_vec(16'h0003, 16'h0004, 16'h0000);

		// 90 degrees about z
		set_rotation(16'h0, 16'h0, 16'd11585, 16'd11585);
		send_vec(16'h0001, 16'h0, 16'h0);
		send_vec(16'h0, 16'h7fff, 16'h0);
		send_vec(16'h0, 16'h0, 16'h0);
		send_vec(16'h1234, 16'hedcb, 16'h0777);
		random_bursts(300);

		// non-unit quaternion, both extremes: saturation
		set_rotation(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_vec(16'h7fff, 16'h0, 16'h0);
		send_vec(16'h0, 16'h8000, 16'h7fff);
		random_bursts(150);
		set_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_vec(16'h0001, 16'h0002, 16'h0003);
		random_bursts(150);

		// 180 degrees about x, then a fixed unit rotation, a random one and a partly random one
		set_rotation(16'd16384, 16'h0, 16'h0, 16'h0);
		random_bursts(300);
		set_rotation(16'd8192, 16'd8192, 16'd8192, 16'd8192);
		random_bursts(300);
		set_rotation(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		random_bursts(300);
		set_rotation(16'($signed($urandom_range(0, 8000)) - 4000), 16'd9000,
			16'($signed($urandom_range(0, 8000)) - 4000), 16'hc000);
		random_bursts(300);

		vec_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/qvr_pkg.sv
hw/rtl/qvr_isqrt.sv
hw/rtl/qvr_div.sv
hw/rtl/quaternion_vector_rotate_unit.sv
tb/qvr_checker.sv
tb/tb_quaternion_vector_rotate_unit.sv
